FILE: hw/rtl/lrust_pkg.sv
// ----------------------------------------------------------------------------
// lrust_pkg
// Shared widths and register indexes for the LRU set-associative tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package lrust_pkg;

    // Result field widths
    localparam int TAG_OUT_W = 30;
    localparam int SET_OUT_W = 6;
    localparam int OFF_OUT_W = 5;
    localparam int CNT_W     = 32;

    // Input address width on the stream
    localparam int ADDR_IN_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd2;

    // Register reset values
    localparam logic [3:0] RST_WAYS_IN_USE = 4'd8;
    localparam logic [2:0] RST_OFFSET_BITS = 3'd2;
    localparam logic [2:0] RST_INDEX_BITS  = 3'd6;

    // Legal line-offset range
    localparam logic [2:0] OFFSET_MIN = 3'd2;
    localparam logic [2:0] OFFSET_MAX = 3'd5;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]     miss_total;
        logic [CNT_W-1:0]     hit_total;
        logic [OFF_OUT_W-1:0] byte_offset;
        logic [SET_OUT_W-1:0] set_index;
        logic [TAG_OUT_W-1:0] tag_value;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_set_associative_tag_store_unit.sv
// ----------------------------------------------------------------------------
// lru_set_associative_tag_store_unit
// LRU set-associative tag store with hit/miss totals.
// ----------------------------------------------------------------------------
// Each input transfer carries a byte address (tdata) and a read/write kind
// (tuser). The address is split into byte offset, set index and tag using the
// configured offset_bits and index_bits; the set row is read from the tag RAM,
// compared across the ways in use, reordered most-recent-first and written
// back. One result transfer follows each input transfer. An access is a RAM
// read followed by a compare and write-back, and the block takes no new
// access until the previous one has been written back and its result
// registered. After reset the block clears the valid bits of every row
// before it accepts its first access; configuration writes are taken at
// any time, but must only be issued while no access is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_set_associative_tag_store_unit #(
    parameter int WAYS      = 8,
    parameter int SETS      = 64,
    parameter int ADDR_BITS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // Configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [lrust_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lrust_pkg::CFG_DATA_W-1:0]    cfg_wdata,

    // Access stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [lrust_pkg::ADDR_IN_W-1:0]     s_tdata,  // [31:0] address
    input  wire logic                                s_tuser,  // [0] kind

    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [29:0] tag_value, [35:30] set_index, [40:36] byte_offset,
    // [72:41] hit_total, [104:73] miss_total, rest zero
    output logic      [lrust_pkg::M_DATA_W-1:0]      m_tdata,
    output logic      [1:0]                          m_tuser   // [0] hit, [1] access_kind
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int STAG_W  = ADDR_BITS - 2;          // offset is at least 2 bits
    localparam int ENT_W   = STAG_W + 1;
    localparam int ROW_W   = WAYS * ENT_W;
    localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WCW     = $clog2(WAYS + 1);
    localparam int MAX_IB  = $clog2(SETS + 1) - 1;   // floor(log2(SETS))
    localparam int IB_CAP  = (MAX_IB > 7) ? 7 : MAX_IB;
    localparam logic [lrust_pkg::ADDR_IN_W-1:0] ADDR_MASK =
        32'hFFFF_FFFF >> (lrust_pkg::ADDR_IN_W - ADDR_BITS);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0] ways_cfg_reg;
    logic [2:0] offset_cfg_reg;
    logic [2:0] index_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_cfg_reg   <= lrust_pkg::RST_WAYS_IN_USE;
            offset_cfg_reg <= lrust_pkg::RST_OFFSET_BITS;
            index_cfg_reg  <= lrust_pkg::RST_INDEX_BITS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lrust_pkg::CFG_WAYS_IN_USE: ways_cfg_reg   <= cfg_wdata;
                lrust_pkg::CFG_OFFSET_BITS: offset_cfg_reg <= cfg_wdata[2:0];
                lrust_pkg::CFG_INDEX_BITS:  index_cfg_reg  <= cfg_wdata[2:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Clamp the registers to the ranges the hardware supports
    logic [WCW-1:0] ways_eff;
    logic [2:0]     offset_eff;
    logic [2:0]     index_eff;

    always_comb begin
        if (ways_cfg_reg == 4'd0) begin
            ways_eff = WCW'(1);
        end else if (32'(ways_cfg_reg) > WAYS) begin
            ways_eff = WCW'(WAYS);
        end else begin
            ways_eff = WCW'(ways_cfg_reg);
        end

        if (offset_cfg_reg < lrust_pkg::OFFSET_MIN) begin
            offset_eff = lrust_pkg::OFFSET_MIN;
        end else if (offset_cfg_reg > lrust_pkg::OFFSET_MAX) begin
            offset_eff = lrust_pkg::OFFSET_MAX;
        end else begin
            offset_eff = offset_cfg_reg;
        end

        if (32'(index_cfg_reg) > IB_CAP) begin
            index_eff = 3'(IB_CAP);
        end else begin
            index_eff = index_cfg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Address split, done on the input transfer
    // ------------------------------------------------------------------
    logic [31:0] addr_m;
    logic [31:0] off_full;
    logic [31:0] set_full;
    logic [31:0] tag_full;
    logic [3:0]  tag_shift;

    always_comb begin
        addr_m    = s_tdata & ADDR_MASK;
        tag_shift = {1'b0, offset_eff} + {1'b0, index_eff};
        off_full  = addr_m & ~(32'hFFFF_FFFF << offset_eff);
        set_full  = (addr_m >> offset_eff) & ~(32'hFFFF_FFFF << index_eff);
        tag_full  = addr_m >> tag_shift;
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    logic [1:0]        state_reg, state_next;
    logic [SET_AW-1:0] clr_addr_reg, clr_addr_next;
    logic              m_valid_reg, m_valid_next;
    logic [lrust_pkg::CNT_W-1:0] hit_cnt_reg, hit_cnt_next;
    logic [lrust_pkg::CNT_W-1:0] miss_cnt_reg, miss_cnt_next;

    // Access held from the input transfer to the lookup (payload, no reset)
    logic                               kind_reg;
    logic [lrust_pkg::TAG_OUT_W-1:0]    tag_reg;
    logic [lrust_pkg::SET_OUT_W-1:0]    set_out_reg;
    logic [SET_AW-1:0]                  set_addr_reg;
    logic [lrust_pkg::OFF_OUT_W-1:0]    off_reg;

    // Result register (payload, no reset)
    lrust_pkg::result_t res_reg, res_next;
    logic               res_hit_reg, res_hit_next;
    logic               res_kind_reg, res_kind_next;

    logic in_xfer;
    logic commit;
    logic hit;

    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    // Finish the lookup once the result register is free or being drained
    assign commit   = (state_reg == ST_LOOKUP) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SET_AW'(SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Totals saturate at all ones
    always_comb begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (commit) begin
            if (hit) begin
                if (hit_cnt_reg != '1) begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end else begin
                if (miss_cnt_reg != '1) begin
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        res_next      = res_reg;
        res_hit_next  = res_hit_reg;
        res_kind_next = res_kind_reg;
        if (commit) begin
            res_next.tag_value   = tag_reg;
            res_next.set_index   = set_out_reg;
            res_next.byte_offset = off_reg;
            res_next.hit_total   = hit_cnt_next;
            res_next.miss_total  = miss_cnt_next;
            res_hit_next         = hit;
            res_kind_next        = kind_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg     <= s_tuser;
            tag_reg      <= tag_full[lrust_pkg::TAG_OUT_W-1:0];
            set_out_reg  <= set_full[lrust_pkg::SET_OUT_W-1:0];
            set_addr_reg <= set_full[SET_AW-1:0];
            off_reg      <= off_full[lrust_pkg::OFF_OUT_W-1:0];
        end
        res_reg      <= res_next;
        res_hit_reg  <= res_hit_next;
        res_kind_reg <= res_kind_next;
    end

    // ------------------------------------------------------------------
    // Tag RAM: one row per set, each way {valid, tag}
    // ------------------------------------------------------------------
    logic              ram_wr_en;
    logic [SET_AW-1:0] ram_wr_addr;
    logic [ROW_W-1:0]  ram_wr_data;

    // Clearing pass writes empty rows; otherwise write back the reordered row
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = commit;
            ram_wr_addr = set_addr_reg;
            ram_wr_data = row_new;
        end
    end

    // Read is issued on the input transfer; the write-back of the previous
    // access has always landed by then, so no forwarding is needed.
    lrust_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (set_full[SET_AW-1:0]),
        .rd_data (row_rd)
    );

    lrust_set_update #(
        .WAYS   (WAYS),
        .STAG_W (STAG_W)
    ) u_set_update (
        .row_in   (row_rd),
        .tag      (tag_reg[STAG_W-1:0]),
        .ways_eff (ways_eff),
        .hit      (hit),
        .row_out  (row_new)
    );

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = lrust_pkg::M_DATA_W'(res_reg);
    assign m_tuser  = {res_kind_reg, res_hit_reg};

endmodule

`default_nettype wire

FILE: hw/rtl/lrust_ram.sv
// ----------------------------------------------------------------------------
// lrust_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lrust_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lrust_set_update.sv
// ----------------------------------------------------------------------------
// lrust_set_update
// Compare one set row against a tag and build the reordered row.
// ----------------------------------------------------------------------------
`default_nettype none

module lrust_set_update #(
    parameter int WAYS   = 8,
    parameter int STAG_W = 30
) (
    input  wire logic [WAYS*(STAG_W+1)-1:0]  row_in,
    input  wire logic [STAG_W-1:0]           tag,
    input  wire logic [$clog2(WAYS+1)-1:0]   ways_eff,
    output logic                             hit,
    output logic      [WAYS*(STAG_W+1)-1:0]  row_out
);

    localparam int ENT_W = STAG_W + 1;
    localparam int WCW   = $clog2(WAYS + 1);

    logic [WAYS-1:0] match;
    logic [WCW-1:0]  hit_way;

    // Entry layout: {valid, tag}
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            match[i] = row_in[i*ENT_W + STAG_W]
                       && (row_in[i*ENT_W +: STAG_W] == tag)
                       && (WCW'(i) < ways_eff);
        end
    end

    // Lowest matching way wins
    always_comb begin
        hit_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_way = WCW'(i);
            end
        end
    end

    assign hit = |match;

    // Way 0 takes the new tag; ways up to the hit way (or the last way in use
    // on a miss) shift back by one; the rest hold.
    always_comb begin
        row_out[0 +: ENT_W] = {1'b1, tag};
        for (int j = 1; j < WAYS; j++) begin
            if (hit ? (WCW'(j) <= hit_way) : (WCW'(j) < ways_eff)) begin
                row_out[j*ENT_W +: ENT_W] = row_in[(j-1)*ENT_W +: ENT_W];
            end else begin
                row_out[j*ENT_W +: ENT_W] = row_in[j*ENT_W +: ENT_W];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU set-associative tag store.
// ----------------------------------------------------------------------------
// The bench holds its own copy of the tag rows, valid bits, hit/miss totals
// and address split. Every access transfer accepted on the s_ stream is
// looked up in that copy. Each m_ transfer is then checked field by field
// against the oldest lookup still waiting. A short directed run fills and
// evicts one set. After it come phases of random accesses. Each phase has
// its own split and associativity, and the out-of-range register values are
// among them. The sender works in bursts and the receiver stalls on its own
// pattern. Between phases all traffic drains before the registers change.
// ----------------------------------------------------------------------------

module tb;

    localparam int NUM_WAYS = 8;
    localparam int NUM_SETS = 64;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Index 3 has no register behind it; writes there must change nothing
    localparam logic [lrust_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int QUIET_CYCLES  = 8;     // settle time once the pipe is empty
    localparam int PHASES        = 12;
    localparam int PHASE_ACCESSES = 118;

    typedef struct packed {
        logic                            kind;
        logic [lrust_pkg::ADDR_IN_W-1:0] addr;
    } access_t;

    typedef struct {
        logic               hit;
        logic               kind;
        lrust_pkg::result_t body;
    } lookup_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [lrust_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lrust_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [lrust_pkg::ADDR_IN_W-1:0]  s_tdata   = '0;  // [31:0] address
    logic                             s_tuser   = 1'b0; // [0] kind
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    // [29:0] tag_value, [35:30] set_index, [40:36] byte_offset,
    // [72:41] hit_total, [104:73] miss_total, rest zero
    logic [lrust_pkg::M_DATA_W-1:0]   m_tdata;
    logic [1:0]                       m_tuser;          // [0] hit, [1] access_kind

    lru_set_associative_tag_store_unit #(
        .WAYS      (NUM_WAYS),
        .SETS      (NUM_SETS),
        .ADDR_BITS (32)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Tag store copy: rows, valid bits, totals and register values
    // ------------------------------------------------------------------------
    logic [lrust_pkg::TAG_OUT_W-1:0] line_tag [NUM_SETS][NUM_WAYS];
    bit                              line_vld [NUM_SETS][NUM_WAYS];
    logic [lrust_pkg::CNT_W-1:0]     hit_count  = '0;
    logic [lrust_pkg::CNT_W-1:0]     miss_count = '0;

    logic [3:0] reg_ways = lrust_pkg::RST_WAYS_IN_USE;
    logic [2:0] reg_off  = lrust_pkg::RST_OFFSET_BITS;
    logic [2:0] reg_idx  = lrust_pkg::RST_INDEX_BITS;

    access_t access_q [$];  // accesses waiting to be sent
    lookup_t lookup_q [$];  // lookups whose result transfer is still due
    int      mismatch_count = 0;

    // Clamp the ways register into 1..NUM_WAYS
    function automatic int active_ways();
        if (reg_ways == 0)
            return 1;
        if (reg_ways > NUM_WAYS)
            return NUM_WAYS;
        return reg_ways;
    endfunction

    // Clamp the offset register into the legal line sizes
    function automatic int line_offset_bits();
        if (reg_off < lrust_pkg::OFFSET_MIN)
            return lrust_pkg::OFFSET_MIN;
        if (reg_off > lrust_pkg::OFFSET_MAX)
            return lrust_pkg::OFFSET_MAX;
        return reg_off;
    endfunction

    // Narrow the index width until its set count fits the array
    function automatic int set_index_bits();
        int b;
        b = reg_idx;
        while (b > 0 && (1 << b) > NUM_SETS)
            b--;
        return b;
    endfunction

    // Build an address from its parts under the current split
    function automatic logic [lrust_pkg::ADDR_IN_W-1:0] compose_address(
            input logic [31:0] tag,
            input logic [31:0] set_sel,
            input logic [31:0] off);
        int ob;
        int ib;
        ob = line_offset_bits();
        ib = set_index_bits();
        return (tag << (ob + ib)) | ((set_sel & ((32'd1 << ib) - 1)) << ob)
             | (off & ((32'd1 << ob) - 1));
    endfunction

    // Look one access up in the tag store copy and update it in LRU order
    function automatic lookup_t lookup_tag_store(
            input logic kind,
            input logic [lrust_pkg::ADDR_IN_W-1:0] addr);
        int                              ob;
        int                              ib;
        int                              nw;
        int                              way;
        int                              i;
        logic [lrust_pkg::TAG_OUT_W-1:0] tag;
        logic [lrust_pkg::SET_OUT_W-1:0] set_sel;
        lookup_t                         r;
        ob      = line_offset_bits();
        ib      = set_index_bits();
        nw      = active_ways();
        tag     = lrust_pkg::TAG_OUT_W'(addr >> (ob + ib));
        set_sel = lrust_pkg::SET_OUT_W'((addr >> ob) & ((32'd1 << ib) - 1));
        r.hit   = 1'b0;
        way     = nw - 1;  // a miss drops the last way in use
        for (i = 0; i < nw; i++) begin
            if (!r.hit && line_vld[set_sel][i] && line_tag[set_sel][i] == tag) begin
                r.hit = 1'b1;
                way   = i;
            end
        end
        // Shift the more recent ways back by one; valid bits move with the tags
        for (i = way; i > 0; i--) begin
            line_tag[set_sel][i] = line_tag[set_sel][i-1];
            line_vld[set_sel][i] = line_vld[set_sel][i-1];
        end
        line_tag[set_sel][0] = tag;
        line_vld[set_sel][0] = 1'b1;
        if (r.hit) begin
            if (hit_count != '1)
                hit_count++;
        end else begin
            if (miss_count != '1)
                miss_count++;
        end
        r.kind             = kind;
        r.body.tag_value   = tag;
        r.body.set_index   = set_sel;
        r.body.byte_offset = lrust_pkg::OFF_OUT_W'(addr & ((32'd1 << ob) - 1));
        r.body.hit_total   = hit_count;
        r.body.miss_total  = miss_count;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: bursts of random length with random gaps, fed from access_q
    // ------------------------------------------------------------------------
    int      burst_left = 0;
    int      gap_left   = 0;
    access_t next_access;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            // Predict at the transfer itself so lookups stay in stream order
            if (s_tvalid && s_tready)
                lookup_q = {lookup_q, lookup_tag_store(s_tuser, s_tdata)};
            // Advance only when the current access is gone or none is held
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || access_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end else begin
                    next_access = access_q.pop_front();
                    s_tvalid    <= 1'b1;
                    s_tdata     <= next_access.addr;
                    s_tuser     <= next_access.kind;
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        // A third of the bursts run straight into the next one
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready pattern switches between free-running, random, sparse
    // and periodic stretches
    // ------------------------------------------------------------------------
    int ready_mode = 0;
    int mode_left  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_mode <= 0;
            mode_left  <= 0;
        end else if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(8, 64);
            m_tready   <= 1'b1;
        end else begin
            mode_left <= mode_left - 1;
            case (ready_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= mode_left[2];
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest lookup
    // ------------------------------------------------------------------------
    lookup_t            want;
    lrust_pkg::result_t seen;

    function automatic void compare_field(input string field, input logic [31:0] expected,
                                          input logic [31:0] actual);
        if (actual !== expected) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, expected, actual);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (lookup_q.size() == 0) begin
                $display("%0t: result transfer with no access outstanding: expected none, "
                         , $time, "actual tuser %h tdata %h", m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = lookup_q.pop_front();
                seen = lrust_pkg::result_t'(m_tdata[lrust_pkg::RESULT_W-1:0]);
                compare_field("hit",         32'(want.hit),              32'(m_tuser[0]));
                compare_field("access_kind", 32'(want.kind),             32'(m_tuser[1]));
                compare_field("tag_value",   32'(want.body.tag_value),   32'(seen.tag_value));
                compare_field("set_index",   32'(want.body.set_index),   32'(seen.set_index));
                compare_field("byte_offset", 32'(want.body.byte_offset), 32'(seen.byte_offset));
                compare_field("hit_total",   want.body.hit_total,        seen.hit_total);
                compare_field("miss_total",  want.body.miss_total,       seen.miss_total);
                compare_field("tdata pad",   32'd0,
                              32'(m_tdata >> lrust_pkg::RESULT_W));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Write one register and mirror it; only called while the pipe is empty
    task automatic write_reg(input logic [lrust_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lrust_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            lrust_pkg::CFG_WAYS_IN_USE: reg_ways = data[3:0];
            lrust_pkg::CFG_OFFSET_BITS: reg_off  = data[2:0];
            lrust_pkg::CFG_INDEX_BITS:  reg_idx  = data[2:0];
            default: ;
        endcase
    endtask

    task automatic queue_access(input logic kind,
                                input logic [lrust_pkg::ADDR_IN_W-1:0] addr);
        access_t a;
        a.kind = kind;
        a.addr = addr;
        access_q = {access_q, a};
    endtask

    // Hold until every queued access has been sent and answered, then settle
    task automatic wait_for_quiet();
        while (access_q.size() != 0 || s_tvalid || lookup_q.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Mostly a small pool of tags over a few neighboring sets, so that hits,
    // evictions and reordering happen often; one access in ten is noise
    task automatic queue_random_accesses(input int count);
        logic [31:0] tag_pool [20];
        int          pool_n;
        int          set_base;
        pool_n   = $urandom_range(1, 2 * active_ways() + 2);
        set_base = $urandom;
        foreach (tag_pool[i])
            tag_pool[i] = $urandom;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0)
                queue_access(1'($urandom_range(0, 1)), $urandom);
            else
                queue_access(1'($urandom_range(0, 1)),
                             compose_address(tag_pool[$urandom_range(0, pool_n - 1)],
                                             set_base + $urandom_range(0, 3), $urandom));
        end
    endtask

    // Fixed settings first: direct-mapped single set, widest split, values
    // below and above the legal ranges, then a shrink and regrow of the ways
    // so that hidden ways come back into use
    logic [lrust_pkg::CFG_DATA_W-1:0] plan_ways [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd8};
    logic [lrust_pkg::CFG_DATA_W-1:0] plan_off  [6] = '{4'd2, 4'd5, 4'd0, 4'hF, 4'd3, 4'd3};
    logic [lrust_pkg::CFG_DATA_W-1:0] plan_idx  [6] = '{4'd0, 4'd6, 4'd7, 4'hE, 4'd1, 4'd1};

    initial begin
        foreach (line_vld[s, w])
            line_vld[s][w] = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Registers are taken during the clearing pass as well
        write_reg(lrust_pkg::CFG_WAYS_IN_USE, 4'd8);
        write_reg(lrust_pkg::CFG_OFFSET_BITS, 4'd2);
        write_reg(lrust_pkg::CFG_INDEX_BITS,  4'd6);

        // Address extremes: all zeros and all ones, each missed then hit
        queue_access(KIND_READ,  32'h0000_0000);
        queue_access(KIND_WRITE, 32'h0000_0003);
        queue_access(KIND_WRITE, 32'hFFFF_FFFF);
        queue_access(KIND_READ,  32'hFFFF_FFFC);
        // Fill set 0 past its ways so the oldest tag drops out
        for (int t = 1; t <= NUM_WAYS; t++)
            queue_access(t[0] ? KIND_WRITE : KIND_READ, compose_address(t, 0, t));
        queue_access(KIND_READ,  compose_address(0, 0, 0));  // evicted: miss
        queue_access(KIND_WRITE, compose_address(5, 0, 1));  // hit in the middle
        queue_access(KIND_READ,  compose_address(2, 0, 2));  // hit in the last way
        queue_access(KIND_WRITE, compose_address(1, 0, 3));  // just dropped: miss
        // Pause the sender here until every result is back
        wait_for_quiet();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 6) begin
                write_reg(lrust_pkg::CFG_WAYS_IN_USE, plan_ways[p]);
                write_reg(lrust_pkg::CFG_OFFSET_BITS, plan_off[p]);
                write_reg(lrust_pkg::CFG_INDEX_BITS,  plan_idx[p]);
            end else begin
                write_reg(lrust_pkg::CFG_WAYS_IN_USE,
                          lrust_pkg::CFG_DATA_W'($urandom_range(0, 15)));
                write_reg(lrust_pkg::CFG_OFFSET_BITS,
                          lrust_pkg::CFG_DATA_W'($urandom_range(0, 15)));
                write_reg(lrust_pkg::CFG_INDEX_BITS,
                          lrust_pkg::CFG_DATA_W'($urandom_range(0, 15)));
            end
            if (p % 3 == 1)
                write_reg(CFG_SPARE_IDX, lrust_pkg::CFG_DATA_W'($urandom_range(0, 15)));
            queue_random_accesses(PHASE_ACCESSES);
            wait_for_quiet();
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/lrust_pkg.sv
hw/rtl/lrust_ram.sv
hw/rtl/lrust_set_update.sv
hw/rtl/lru_set_associative_tag_store_unit.sv
sim/tb.sv
